// ----- rtl/lgs_pkg.sv -----
package lgs_pkg;

   // grid geometry
   localparam int ROWS  = 16;
   localparam int COLS  = 16;
   localparam int ROW_W = $clog2(ROWS);
   localparam int GEN_W = 10;
   localparam int KIND_W = 2;

   localparam logic [GEN_W-1:0] LIMIT_RESET = GEN_W'(1000);

   // request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD = 2'd0,
      KIND_STEP = 2'd1,
      KIND_READ = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_FILL,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic     load;
      logic     rd_req;
      logic     prime;
      logic     fill;
      logic     sweep;
      logic     finish;
      kind_type fin_kind;
      logic     fin_stop;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic dead;
      logic at_limit;
      logic sweep_last;
      logic rsp_free;
   } status_type;

   // next generation of one row from its three-row window
   function automatic logic [COLS-1:0] life_row(input logic [COLS-1:0] above,
                                                input logic [COLS-1:0] here,
                                                input logic [COLS-1:0] below);
      logic [COLS+1:0] a;
      logic [COLS+1:0] h;
      logic [COLS+1:0] b;
      logic [3:0]      n;
      logic [COLS-1:0] res;
      a = {1'b0, above, 1'b0};
      h = {1'b0, here, 1'b0};
      b = {1'b0, below, 1'b0};
      res = '0;
      for (int c = 0; c < COLS; c++) begin
         n = 4'(a[c]) + 4'(a[c+1]) + 4'(a[c+2])
           + 4'(h[c]) + 4'(h[c+2])
           + 4'(b[c]) + 4'(b[c+1]) + 4'(b[c+2]);
         res[c] = (n == 4'd3) || ((n == 4'd2) && h[c+1]);
      end
      return res;
   endfunction

endpackage

// ----- rtl/lgs_ctrl.sv -----
module lgs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  lgs_pkg::kind_type     req_kind,
   output logic                  req_stall,
   input  lgs_pkg::status_type   status,
   output lgs_pkg::cmd_type      cmd
);
   import lgs_pkg::*;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   logic      stop_ff, stop_in;
   logic      accept;
   logic      stop_now;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign stop_now  = status.dead || status.at_limit;

   // next state
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      stop_in  = stop_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_kind;
               stop_in = (req_kind == KIND_STEP) && stop_now;
               if ((req_kind == KIND_STEP) && !stop_now) begin
                  state_in = ST_PRIME;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_PRIME: state_in = ST_FILL;
         ST_FILL:  state_in = ST_SWEEP;
         ST_SWEEP: begin
            if (status.sweep_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd          = '0;
      cmd.fin_kind = kind_ff;
      cmd.fin_stop = stop_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.load   = accept && (req_kind == KIND_LOAD);
            cmd.rd_req = accept && (req_kind == KIND_READ);
         end
         ST_PRIME:  cmd.prime = 1'b1;
         ST_FILL:   cmd.fill = 1'b1;
         ST_SWEEP:  cmd.sweep = 1'b1;
         ST_FINISH: cmd.finish = status.rsp_free;
         default: begin
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= KIND_NONE;
         stop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         stop_ff  <= stop_in;
      end
   end

   // checks
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.rd_req, cmd.prime, cmd.fill, cmd.sweep, cmd.finish}))
      else $error("more than one datapath command at once");

   a_step_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_kind == KIND_STEP) && !stop_now) |=> (state_ff == ST_PRIME))
      else $error("accepted step did not start the sweep");

   a_sweep_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SWEEP) && !status.sweep_last) |=> (state_ff == ST_SWEEP))
      else $error("sweep left before the last row");

endmodule

// ----- rtl/lgs_datapath.sv -----
module lgs_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  lgs_pkg::cmd_type             cmd,
   output lgs_pkg::status_type          status,
   input  logic [lgs_pkg::ROW_W-1:0]    req_row_index,
   input  logic [lgs_pkg::COLS-1:0]     req_cells_in,
   input  logic                         csr_wr_en,
   input  logic [lgs_pkg::GEN_W-1:0]    csr_wr_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [lgs_pkg::COLS-1:0]     rsp_cells_out,
   output logic [lgs_pkg::GEN_W-1:0]    rsp_generation,
   output logic                         rsp_all_dead,
   output logic                         rsp_unchanged,
   output logic                         rsp_stopped
);
   import lgs_pkg::*;

   // grid memory and per-row flags
   logic [COLS-1:0]  grid_mem [ROWS];
   logic [ROWS-1:0]  row_valid_ff;
   logic [ROWS-1:0]  row_live_ff;
   logic [COLS-1:0]  rd_data_ff;
   logic             rd_valid_ff;

   logic             rd_en;
   logic [ROW_W-1:0] rd_addr;
   logic             wr_en;
   logic [ROW_W-1:0] wr_addr;
   logic [COLS-1:0]  wr_data;
   logic [COLS-1:0]  rd_eff;

   // window and sweep state
   logic [COLS-1:0]  above_ff;
   logic [COLS-1:0]  here_ff;
   logic [COLS-1:0]  below;
   logic [COLS-1:0]  next_row;
   logic [ROW_W-1:0] sweep_ff;
   logic             changed_ff;
   logic [GEN_W-1:0] gen_ff;
   logic [GEN_W-1:0] limit_ff;

   logic             rsp_valid_ff;
   logic [COLS-1:0]  cells_out_ff;
   logic [GEN_W-1:0] gen_out_ff;
   logic             dead_out_ff;
   logic             unchanged_ff;
   logic             stopped_ff;

   assign rd_eff   = rd_valid_ff ? rd_data_ff : '0;
   assign below    = (sweep_ff == ROW_W'(ROWS - 1)) ? '0 : rd_eff;
   assign next_row = life_row(above_ff, here_ff, below);

   // read address select
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = req_row_index;
      if (cmd.rd_req) begin
         rd_en = 1'b1;
      end else if (cmd.prime) begin
         rd_en   = 1'b1;
         rd_addr = '0;
      end else if (cmd.fill) begin
         rd_en   = 1'b1;
         rd_addr = ROW_W'(1);
      end else if (cmd.sweep) begin
         rd_en   = (sweep_ff < ROW_W'(ROWS - 2));
         rd_addr = ROW_W'(sweep_ff + ROW_W'(2));
      end
   end

   // write address select
   always_comb begin
      wr_en   = cmd.load || cmd.sweep;
      wr_addr = cmd.sweep ? sweep_ff : req_row_index;
      wr_data = cmd.sweep ? next_row : req_cells_in;
   end

   // grid storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= grid_mem[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   // row valid and nonzero flags
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         row_live_ff  <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
         row_live_ff[wr_addr]  <= |wr_data;
      end
   end

   // three-row window
   always_ff @(posedge clock) begin
      if (cmd.fill) begin
         above_ff <= '0;
         here_ff  <= rd_eff;
      end else if (cmd.sweep) begin
         above_ff <= here_ff;
         here_ff  <= below;
      end
   end

   // sweep counter, change tracking, generation count, limit
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff   <= '0;
         changed_ff <= 1'b0;
         gen_ff     <= '0;
         limit_ff   <= LIMIT_RESET;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (cmd.fill) begin
            sweep_ff   <= '0;
            changed_ff <= 1'b0;
         end else if (cmd.sweep) begin
            sweep_ff   <= ROW_W'(sweep_ff + ROW_W'(1));
            changed_ff <= changed_ff || (next_row != here_ff);
         end
         if (cmd.load) begin
            gen_ff <= '0;
         end else if (cmd.sweep && status.sweep_last) begin
            gen_ff <= GEN_W'(gen_ff + GEN_W'(1));
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         cells_out_ff <= (cmd.fin_kind == KIND_READ) ? rd_eff : '0;
         gen_out_ff   <= gen_ff;
         dead_out_ff  <= ~|row_live_ff;
         unchanged_ff <= (cmd.fin_kind == KIND_STEP) && !cmd.fin_stop && !changed_ff;
         stopped_ff   <= (cmd.fin_kind == KIND_STEP) && cmd.fin_stop;
      end
   end

   // status to controller
   assign status.dead       = ~|row_live_ff;
   assign status.at_limit   = (gen_ff >= limit_ff);
   assign status.sweep_last = (sweep_ff == ROW_W'(ROWS - 1));
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cells_out  = cells_out_ff;
   assign rsp_generation = gen_out_ff;
   assign rsp_all_dead   = dead_out_ff;
   assign rsp_unchanged  = unchanged_ff;
   assign rsp_stopped    = stopped_ff;

   // checks
   a_gen_bump: assert property (@(posedge clock) disable iff (reset)
      (cmd.sweep && status.sweep_last) |=> (gen_ff == GEN_W'($past(gen_ff) + GEN_W'(1))))
      else $error("generation count not advanced at end of sweep");

   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && !cmd.finish) |=> (rsp_valid_ff && $stable(cells_out_ff)))
      else $error("stalled result dropped or changed");

   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished request did not raise the result");

endmodule

// ----- rtl/life_grid_generation_step_unit.sv -----
// Game of Life (birth on 3, survive on 2 or 3) on a 16x16 grid with a dead
// border. A load request writes one row and clears the generation count, a
// read request returns one row, and a step request advances the whole grid
// one generation unless the grid is all dead or the count has reached
// generation_limit (then the result has stopped set and nothing changes).
// Load, read, refused-step and unused-kind requests go from acceptance to
// the finish state; a performed step first takes the prime and fill states,
// which load the three-row window from the grid memory (one read port and
// one write port), and the sweep, which slides the window down the grid and
// writes each new row back, before the finish state registers the result.
// The grid memory reads as all dead after reset through per-row valid flags,
// so there is no clearing pass. One request is in work at a time; a finished
// result waits in the output register while the next request is accepted.
module life_grid_generation_step_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [lgs_pkg::KIND_W-1:0]  req_kind,
   input  logic [lgs_pkg::ROW_W-1:0]   req_row_index,
   input  logic [lgs_pkg::COLS-1:0]    req_cells_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lgs_pkg::COLS-1:0]    rsp_cells_out,
   output logic [lgs_pkg::GEN_W-1:0]   rsp_generation,
   output logic                        rsp_all_dead,
   output logic                        rsp_unchanged,
   output logic                        rsp_stopped,
   input  logic                        csr_wr_en,
   input  logic [lgs_pkg::GEN_W-1:0]   csr_wr_data
);
   import lgs_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   lgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (kind_type'(req_kind)),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // grid storage, window and result register
   lgs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_row_index  (req_row_index),
      .req_cells_in   (req_cells_in),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cells_out  (rsp_cells_out),
      .rsp_generation (rsp_generation),
      .rsp_all_dead   (rsp_all_dead),
      .rsp_unchanged  (rsp_unchanged),
      .rsp_stopped    (rsp_stopped)
   );

endmodule

// ----- sim/life_grid_generation_step_unit_test.sv -----
`timescale 1ns / 1ps

module life_grid_generation_step_unit_test;
   import lgs_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 1500;
   localparam int MAX_REPORTS  = 10;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   logic [1:0]   req_kind = '0;
   logic [3:0]   req_row_index = '0;
   logic [15:0]  req_cells_in = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   logic [15:0]  rsp_cells_out;
   logic [9:0]   rsp_generation;
   logic         rsp_all_dead;
   logic         rsp_unchanged;
   logic         rsp_stopped;
   logic         csr_wr_en = 1'b0;
   logic [9:0]   csr_wr_data = '0;

   // one expected result per request
   typedef struct {
      logic [15:0] cells;
      logic [9:0]  gen;
      logic        dead;
      logic        unchanged;
      logic        stopped;
   } life_result_type;

   life_result_type pending_results[$];

   // shadow copy of the grid, the count and the limit register
   logic [15:0] grid_model [ROWS];
   logic [9:0]  gen_model;
   logic [9:0]  limit_model;

   int mismatch_count = 0;
   int items_sent = 0;
   int random_base = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit no_idle = 1'b0;

   always #1 clock = ~clock;

   life_grid_generation_step_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_row_index  (req_row_index),
      .req_cells_in   (req_cells_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cells_out  (rsp_cells_out),
      .rsp_generation (rsp_generation),
      .rsp_all_dead   (rsp_all_dead),
      .rsp_unchanged  (rsp_unchanged),
      .rsp_stopped    (rsp_stopped),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   // next state of one row, border cells count as dead
   function automatic logic [15:0] evolve_row(input logic [15:0] above,
                                              input logic [15:0] here,
                                              input logic [15:0] below);
      logic [15:0] res;
      int          n;
      int          col;
      res = '0;
      for (int c = 0; c < COLS; c++) begin
         n = 0;
         for (int dc = -1; dc <= 1; dc++) begin
            col = c + dc;
            if (col >= 0 && col < COLS) begin
               n += int'(above[col]) + int'(below[col]);
               if (dc != 0) n += int'(here[col]);
            end
         end
         res[c] = (n == 3) || (n == 2 && here[c]);
      end
      return res;
   endfunction

   function automatic bit grid_dead();
      for (int r = 0; r < ROWS; r++)
         if (grid_model[r] != '0) return 1'b0;
      return 1'b1;
   endfunction

   // update the shadow state for one accepted request and queue its result
   function automatic void apply_request(input kind_type k, input logic [3:0] row,
                                         input logic [15:0] cells);
      life_result_type res;
      logic [15:0]  prev [ROWS];
      logic [15:0]  above;
      logic [15:0]  below;
      bit           same;
      res = '{cells: '0, gen: '0, dead: 1'b0, unchanged: 1'b0, stopped: 1'b0};
      case (k)
         KIND_LOAD: begin
            grid_model[row] = cells;
            gen_model = '0;
         end
         KIND_STEP: begin
            if (grid_dead() || gen_model >= limit_model) begin
               res.stopped = 1'b1;
            end else begin
               prev = grid_model;
               same = 1'b1;
               for (int r = 0; r < ROWS; r++) begin
                  above = (r > 0) ? prev[r-1] : '0;
                  below = (r < ROWS - 1) ? prev[r+1] : '0;
                  grid_model[r] = evolve_row(above, prev[r], below);
                  if (grid_model[r] != prev[r]) same = 1'b0;
               end
               gen_model = gen_model + 10'd1;
               res.unchanged = same;
            end
         end
         KIND_READ: begin
            res.cells = grid_model[row];
         end
         default: begin
         end
      endcase
      res.gen  = gen_model;
      res.dead = grid_dead();
      pending_results.push_back(res);
   endfunction

   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // send one request; valid stays high afterwards unless a gap follows
   task automatic send_request(input kind_type k, input logic [3:0] row,
                               input logic [15:0] cells);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= k;
      req_row_index <= row;
      req_cells_in  <= cells;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_request(k, row, cells);
      if (k != KIND_NONE) items_sent++;
   endtask

   // hold off requests until every result has come back
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [9:0] value);
      wait_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      limit_model = value;
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_grid(input logic [15:0] rows [ROWS]);
      for (int r = 0; r < ROWS; r++) send_request(KIND_LOAD, 4'(r), rows[r]);
   endtask

   function automatic logic [15:0] random_row(input int density);
      case (density)
         0: return 16'($urandom & $urandom & $urandom);
         1: return 16'($urandom & $urandom);
         2: return 16'($urandom);
         default: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'($urandom | $urandom);
      endcase
   endfunction

   function automatic logic [9:0] random_limit();
      int roll;
      roll = $urandom_range(0, 9);
      case (roll)
         0: return 10'd0;
         1: return 10'd1;
         2: return 10'd1023;
         3, 4: return 10'($urandom_range(2, 30));
         default: return 10'($urandom_range(31, 1023));
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      life_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result: cells %h gen %0d dead %b unch %b stop %b",
                        rsp_cells_out, rsp_generation, rsp_all_dead, rsp_unchanged,
                        rsp_stopped);
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_cells_out !== exp_res.cells || rsp_generation !== exp_res.gen ||
                rsp_all_dead !== exp_res.dead || rsp_unchanged !== exp_res.unchanged ||
                rsp_stopped !== exp_res.stopped) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"mismatch: expected cells %h gen %0d dead %b unch %b stop %b,",
                            " got cells %h gen %0d dead %b unch %b stop %b"},
                           exp_res.cells, exp_res.gen, exp_res.dead, exp_res.unchanged,
                           exp_res.stopped, rsp_cells_out, rsp_generation, rsp_all_dead,
                           rsp_unchanged, rsp_stopped);
            end
         end
      end
   end

   // random backpressure on the result side
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (no_idle || $urandom_range(0, 99) < 75) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b1;
         stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
                                                    : $urandom_range(10, 50);
      end
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("life_grid_generation_step_unit_test: errors");
         $finish;
      end
   end

   // empty grid after reset: reads are zero, a step is refused, unused kind
   task automatic test_empty_grid();
      send_request(KIND_READ, 4'd0, 16'hFFFF);
      send_request(KIND_STEP, 4'd15, 16'h0000);
      send_request(KIND_NONE, 4'd15, 16'hFFFF);
   endtask

   // full first and last rows against the dead border
   task automatic test_edge_rows();
      send_request(KIND_LOAD, 4'd0, 16'hFFFF);
      send_request(KIND_LOAD, 4'd15, 16'hFFFF);
      send_request(KIND_STEP, 4'd0, 16'h0000);
      send_request(KIND_READ, 4'd0, 16'h0000);
      send_request(KIND_READ, 4'd1, 16'h0000);
      send_request(KIND_READ, 4'd15, 16'h0000);
      send_request(KIND_LOAD, 4'd0, 16'h0000);
      send_request(KIND_LOAD, 4'd1, 16'h0000);
      send_request(KIND_LOAD, 4'd14, 16'h0000);
      send_request(KIND_LOAD, 4'd15, 16'h0000);
   endtask

   // blinker oscillates, block on the left edge is a still life
   task automatic test_oscillator_and_still_life();
      send_request(KIND_LOAD, 4'd5, 16'h0100);
      send_request(KIND_LOAD, 4'd6, 16'h0100);
      send_request(KIND_LOAD, 4'd7, 16'h0100);
      send_request(KIND_STEP, 4'd0, 16'h0000);
      send_request(KIND_READ, 4'd6, 16'h0000);
      send_request(KIND_STEP, 4'd0, 16'h0000);
      send_request(KIND_LOAD, 4'd5, 16'h0000);
      send_request(KIND_LOAD, 4'd6, 16'h0003);
      send_request(KIND_LOAD, 4'd7, 16'h0003);
      send_request(KIND_STEP, 4'd0, 16'h0000);
      send_request(KIND_NONE, 4'd0, 16'h0000);
   endtask

   // limit of zero refuses every step, limit of one allows a single step
   task automatic test_limit_settings();
      write_limit(10'd0);
      send_request(KIND_STEP, 4'd0, 16'h0000);
      write_limit(10'd1);
      send_request(KIND_LOAD, 4'd0, 16'h0000);
      send_request(KIND_STEP, 4'd0, 16'h0000);
      send_request(KIND_STEP, 4'd0, 16'h0000);
      write_limit(10'd1023);
   endtask

   // long run of a block and a blinker until the count hits a high limit
   task automatic test_count_to_limit();
      logic [15:0] rows [ROWS];
      logic [9:0]  lim;
      int          br;
      int          bc;
      int          bl;
      int          steps;
      lim = 10'($urandom_range(520, 560));
      write_limit(lim);
      for (int r = 0; r < ROWS; r++) rows[r] = '0;
      br = $urandom_range(0, 2);
      bc = $urandom_range(0, 14);
      rows[br]   = 16'h0003 << bc;
      rows[br+1] = 16'h0003 << bc;
      bl = $urandom_range(1, 14);
      if ($urandom_range(0, 1) != 0) begin
         rows[8]  = 16'h0001 << bl;
         rows[9]  = 16'h0001 << bl;
         rows[10] = 16'h0001 << bl;
      end else begin
         rows[9] = 16'h0007 << (bl - 1);
      end
      load_grid(rows);
      steps = 0;
      while (steps < int'(lim) + 2) begin
         if ($urandom_range(0, 9) == 0) begin
            send_request(KIND_READ, 4'($urandom_range(0, 15)), 16'($urandom));
         end else begin
            send_request(KIND_STEP, 4'($urandom_range(0, 15)), 16'($urandom));
            steps++;
         end
      end
   endtask

   // random grids and limits, runs of steps mixed with reads, loads and noise
   task automatic test_random_evolution();
      logic [15:0] rows [ROWS];
      int          density;
      int          roll;
      while (items_sent < random_base + RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 3) == 0) write_limit(random_limit());
         density = $urandom_range(0, 3);
         if ($urandom_range(0, 2) != 0) begin
            for (int r = 0; r < ROWS; r++) rows[r] = random_row(density);
            load_grid(rows);
         end else begin
            repeat ($urandom_range(1, 4))
               send_request(KIND_LOAD, 4'($urandom_range(0, 15)), random_row(density));
         end
         repeat ($urandom_range(5, 40)) begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
               send_request(KIND_STEP, 4'($urandom_range(0, 15)), 16'($urandom));
            else if (roll < 88)
               send_request(KIND_READ, 4'($urandom_range(0, 15)), 16'($urandom));
            else if (roll < 95)
               send_request(KIND_LOAD, 4'($urandom_range(0, 15)), random_row(density));
            else
               send_request(KIND_NONE, 4'($urandom_range(0, 15)), 16'($urandom));
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      for (int r = 0; r < ROWS; r++) grid_model[r] = '0;
      gen_model   = '0;
      limit_model = LIMIT_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_grid();
      test_edge_rows();
      test_oscillator_and_still_life();
      test_limit_settings();
      random_base = items_sent;
      test_count_to_limit();
      test_random_evolution();
      wait_drain();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("life_grid_generation_step_unit_test: clean");
      else
         $display("life_grid_generation_step_unit_test: errors");
      $finish;
   end

endmodule
